@@ rtl/anb_pkg.sv @@
// ----------------------------------------------------------------------------
// Annex B splitter package
// Shared constants, widths and the command record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package anb_pkg;

    // Width of the unit length counter; the output field stays 32 bits.
    localparam int LENGTH_WIDTH = 32;
    localparam int LEN_OUT_W    = 32;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic [6:0] TYPE_VPS = 7'h20;
    localparam logic [6:0] TYPE_SPS = 7'h21;
    localparam logic [6:0] TYPE_PPS = 7'h22;

    localparam logic [1:0] HELD_MAX = 2'd2;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [0:0] KIND_PAYLOAD = 1'b0;
    localparam logic [0:0] KIND_END     = 1'b1;

    // Everything one input byte causes: held zeros, the byte itself and an
    // end record, in that order.
    typedef struct packed {
        logic [1:0]              n_zeros;
        logic                    has_byte;
        logic [7:0]              data_byte;
        logic                    has_end;
        logic [LENGTH_WIDTH-1:0] length;
        logic [6:0]              unit_type;
        logic                    is_ps;
    } t_cmd;

    function automatic logic is_param_set(input logic [6:0] t);
        return (t == TYPE_VPS) || (t == TYPE_SPS) || (t == TYPE_PPS);
    endfunction

endpackage

`default_nettype wire

@@ rtl/anb_if.sv @@
// ----------------------------------------------------------------------------
// Annex B splitter channels
// Valid/ready channels for input bytes and for result records.
// ----------------------------------------------------------------------------
`default_nettype none

interface anb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       final_byte;

    modport source (output valid, output stream_byte, output final_byte, input ready);
    modport sink   (input valid, input stream_byte, input final_byte, output ready);
endinterface

interface anb_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] unit_length;
    logic [6:0]  unit_type;
    logic        is_parameter_set;
    logic        last_of_run;

    modport source (output valid, output kind, output payload_byte, output unit_length,
                    output unit_type, output is_parameter_set, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input unit_length,
                    input unit_type, input is_parameter_set, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/anb_front.sv @@
// ----------------------------------------------------------------------------
// Annex B splitter front end
// Classifies each byte, tracks start code state and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module anb_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    anb_in_if.sink           i_in,
    input  wire logic        i_q_full,
    output anb_pkg::t_cmd    o_cmd,
    output logic             o_push
);
    import anb_pkg::*;

    localparam logic [LENGTH_WIDTH+1:0] LEN_SAT = {2'b00, {LENGTH_WIDTH{1'b1}}};

    logic [1:0]              r_held, n_held;
    logic                    r_inside, n_inside;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [6:0]              r_type, n_type;

    logic                    accept;
    logic                    cmd_valid;
    logic [1:0]              n_pay;
    logic [LENGTH_WIDTH+1:0] len_sum;
    logic [LENGTH_WIDTH-1:0] len_new;
    logic [6:0]              type_new;
    t_cmd                    cmd;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        cmd       = '0;
        cmd_valid = 1'b0;
        n_held    = r_held;
        n_inside  = r_inside;

        priority if (i_in.final_byte) begin
            if (r_inside) begin
                cmd.n_zeros   = r_held;
                cmd.has_byte  = 1'b1;
                cmd.data_byte = i_in.stream_byte;
                cmd.has_end   = 1'b1;
                cmd_valid     = 1'b1;
            end
            n_held   = 2'd0;
            n_inside = 1'b0;
        end else if (i_in.stream_byte == BYTE_ZERO) begin
            if (r_held < HELD_MAX) begin
                n_held = r_held + 2'd1;
            end else if (r_inside) begin
                cmd.has_byte  = 1'b1;
                cmd.data_byte = BYTE_ZERO;
                cmd_valid     = 1'b1;
            end
        end else if (i_in.stream_byte == BYTE_ONE && r_held == HELD_MAX) begin
            if (r_inside && r_len != '0) begin
                cmd.has_end = 1'b1;
                cmd_valid   = 1'b1;
            end
            n_held   = 2'd0;
            n_inside = 1'b1;
        end else begin
            if (r_inside) begin
                cmd.n_zeros   = r_held;
                cmd.has_byte  = 1'b1;
                cmd.data_byte = i_in.stream_byte;
                cmd_valid     = 1'b1;
            end
            n_held = 2'd0;
        end

        // Length and type after the payload of this byte.
        n_pay   = cmd.n_zeros + {1'b0, cmd.has_byte};
        len_sum = {2'b00, r_len} + {{LENGTH_WIDTH{1'b0}}, n_pay};
        len_new = (len_sum > LEN_SAT) ? LEN_SAT[LENGTH_WIDTH-1:0]
                                      : len_sum[LENGTH_WIDTH-1:0];
        if (r_len == '0 && n_pay != 2'd0) begin
            type_new = (cmd.n_zeros != 2'd0) ? 7'd0 : cmd.data_byte[7:1];
        end else begin
            type_new = r_type;
        end

        cmd.length    = len_new;
        cmd.unit_type = type_new;
        cmd.is_ps     = is_param_set(type_new);

        n_len  = len_new;
        n_type = type_new;
        // A final byte or a start code begins from an empty unit.
        if (i_in.final_byte || (i_in.stream_byte == BYTE_ONE && r_held == HELD_MAX)) begin
            n_len  = '0;
            n_type = 7'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 2'd0;
            r_inside <= 1'b0;
            r_len    <= '0;
            r_type   <= 7'd0;
        end else if (accept) begin
            r_held   <= n_held;
            r_inside <= n_inside;
            r_len    <= n_len;
            r_type   <= n_type;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && cmd_valid;

endmodule

`default_nettype wire

@@ rtl/anb_queue.sv @@
// ----------------------------------------------------------------------------
// Annex B splitter command queue
// A short first-in first-out store of commands from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

module anb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire anb_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output anb_pkg::t_cmd      o_head,
    output logic               o_empty,
    output logic               o_full
);
    import anb_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = do_pop  ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/anb_back.sv @@
// ----------------------------------------------------------------------------
// Annex B splitter back end
// Expands each command into result records, one record per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module anb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire anb_pkg::t_cmd i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    anb_out_if.source          o_out
);
    import anb_pkg::*;

    logic [1:0]  r_zeros_done, n_zeros_done;
    logic        r_byte_done, n_byte_done;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_byte;
    logic [31:0] r_len;
    logic [6:0]  r_type;
    logic        r_ps;
    logic        r_last;

    logic        slot_free;
    logic        emit;
    logic        res_kind;
    logic [7:0]  res_byte;
    logic [31:0] res_len;
    logic [6:0]  res_type;
    logic        res_ps;
    logic        res_last;

    assign slot_free = !r_valid || o_out.ready;
    assign emit      = slot_free && !i_empty;

    // Pick the next record of the head command from its progress.
    always_comb begin
        res_kind     = KIND_PAYLOAD;
        res_byte     = 8'd0;
        res_len      = 32'd0;
        res_type     = 7'd0;
        res_ps       = 1'b0;
        res_last     = 1'b1;
        n_zeros_done = r_zeros_done;
        n_byte_done  = r_byte_done;

        priority if (r_zeros_done < i_head.n_zeros) begin
            res_last     = (r_zeros_done + 2'd1 == i_head.n_zeros)
                           && !i_head.has_byte && !i_head.has_end;
            n_zeros_done = r_zeros_done + 2'd1;
        end else if (i_head.has_byte && !r_byte_done) begin
            res_byte    = i_head.data_byte;
            res_last    = !i_head.has_end;
            n_byte_done = 1'b1;
        end else begin
            res_kind = KIND_END;
            res_len  = LEN_OUT_W'(i_head.length);
            res_type = i_head.unit_type;
            res_ps   = i_head.is_ps;
        end

        if (res_last) begin
            n_zeros_done = 2'd0;
            n_byte_done  = 1'b0;
        end
    end

    assign o_pop = emit && res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zeros_done <= 2'd0;
            r_byte_done  <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (emit) begin
                r_zeros_done <= n_zeros_done;
                r_byte_done  <= n_byte_done;
            end
            if (slot_free) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= res_kind;
            r_byte <= res_byte;
            r_len  <= res_len;
            r_type <= res_type;
            r_ps   <= res_ps;
            r_last <= res_last;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.kind             = r_kind;
    assign o_out.payload_byte     = r_byte;
    assign o_out.unit_length      = r_len;
    assign o_out.unit_type        = r_type;
    assign o_out.is_parameter_set = r_ps;
    assign o_out.last_of_run      = r_last;

endmodule

`default_nettype wire

@@ rtl/annexb_nal_unit_splitter.sv @@
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter
// Splits a byte stream at 00 00 01 start codes into payload bytes and
// end-of-unit records carrying length, type and a parameter set flag.
// ----------------------------------------------------------------------------
// A byte's records pass through the command queue and then the output register.
// One byte per cycle goes in while each byte gives at most one record and the
// receiver is ready; the output register issues one record per cycle while the
// receiver is ready, and a four-entry command queue absorbs the bursts of bytes
// that release held zeros or end a unit. Reset (synchronous, active low) empties
// the queue and output register and returns to the state before any start code.
`default_nettype none

module annexb_nal_unit_splitter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    anb_in_if.sink    i_in,
    anb_out_if.source o_out
);
    import anb_pkg::*;

    // Commands travel from the front to the back through the queue. The front
    // owns all stream state (held zeros, unit length and type) and resolves a
    // byte completely at its transaction; the back only serializes records.
    t_cmd front_cmd;
    t_cmd q_head;
    logic front_push;
    logic q_empty;
    logic q_full;
    logic back_pop;

    // Front: classifies each byte against the start code pattern. It stalls
    // the input only when the queue is full.
    anb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_q_full(q_full),
        .o_cmd   (front_cmd),
        .o_push  (front_push)
    );

    anb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_cmd  (front_cmd),
        .i_pop  (back_pop),
        .o_head (q_head),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    // Back: walks the head command (zeros, then the byte, then the end record)
    // and pops it as its last record enters the output register.
    anb_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (q_head),
        .i_empty(q_empty),
        .o_pop  (back_pop),
        .o_out  (o_out)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_annexb_nal_unit_splitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter testbench
// Feeds directed and randomized Annex B byte streams through the splitter,
// predicts every payload byte and end-of-unit record in a behavioral model
// kept inside this module, and checks each output transaction in order while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_annexb_nal_unit_splitter;

    import anb_pkg::*;

    // Stream bytes in the randomized part, on top of the directed opening.
    localparam int RANDOM_ITEMS = 300;
    // Hard ceiling on the run; a correct run needs a small fraction of it.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to watch the output after the last expected record.
    localparam int DRAIN_CYCLES = 24;
    // Long receiver hold-off, started once the stream is well under way.
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 280;
    // Idle phase boundaries, counted in accepted stream bytes.
    localparam int PHASE_A_END  = 120;
    localparam int PHASE_B_END  = 240;

    // One byte of the elementary stream as offered on the input channel.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_es_item;

    // One output record, in the order of the output channel fields.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] unit_length;
        logic [6:0]  unit_type;
        logic        is_parameter_set;
        logic        last_of_run;
    } t_nal_rec;

    logic i_clk;
    logic i_rst_n;

    anb_in_if  in_bus ();
    anb_out_if out_bus ();

    annexb_nal_unit_splitter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Bytes waiting to be offered, and records waiting to be seen.
    t_es_item stream_q[$];
    t_nal_rec expected_records[$];
    // Records caused by the byte being predicted right now.
    t_nal_rec step_recs[$];

    // Splitter state as this testbench tracks it.
    logic [1:0]              held_zeros    = 2'd0;
    logic                    in_unit       = 1'b0;
    logic [LENGTH_WIDTH-1:0] unit_bytes    = '0;
    logic [6:0]              unit_type_cur = 7'd0;

    int bytes_sent     = 0;
    int records_seen   = 0;
    int units_ended    = 0;
    int ps_units       = 0;
    int streams_closed = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    int send_idle_pct;
    int recv_idle_pct;

    // ------------------------------------------------------------------------
    // Clock and reset. Reset is applied once.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Three idle phases: a slow sender with a very slow receiver, then the
    // reverse, then both at full rate. The long hold-off falls in the last
    // phase, where the sender never pauses, so the block has to back up.
    always_comb begin
        if (bytes_sent < PHASE_A_END) begin
            send_idle_pct = 33;
            recv_idle_pct = 67;
        end else if (bytes_sent < PHASE_B_END) begin
            send_idle_pct = 67;
            recv_idle_pct = 33;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction. Payload bytes count toward the current unit and the first
    // of them fixes the unit type; an end record carries the count, and is
    // left out for a unit that never got a payload byte.
    // ------------------------------------------------------------------------
    task automatic add_payload(input logic [7:0] value);
        t_nal_rec rec;
        if (unit_bytes == '0) begin
            unit_type_cur = value[7:1];
        end
        if (unit_bytes != '1) begin
            unit_bytes = unit_bytes + 1'b1;
        end
        rec                  = '0;
        rec.kind             = KIND_PAYLOAD;
        rec.payload_byte     = value;
        step_recs.push_back(rec);
    endtask

    task automatic add_unit_end();
        t_nal_rec rec;
        if (unit_bytes != '0) begin
            rec                  = '0;
            rec.kind             = KIND_END;
            rec.unit_length      = LEN_OUT_W'(unit_bytes);
            rec.unit_type        = unit_type_cur;
            rec.is_parameter_set = (unit_type_cur >= TYPE_VPS) && (unit_type_cur <= TYPE_PPS);
            step_recs.push_back(rec);
        end
    endtask

    // Zeros held back are released as payload when they turn out not to
    // belong to a start code.
    task automatic release_held_zeros();
        int i;
        for (i = 0; i < held_zeros; i++) begin
            add_payload(BYTE_ZERO);
        end
    endtask

    task automatic clear_stream_state();
        held_zeros    = 2'd0;
        in_unit       = 1'b0;
        unit_bytes    = '0;
        unit_type_cur = 7'd0;
    endtask

    // Works out every record one accepted stream byte causes and queues them.
    task automatic split_byte(input logic [7:0] data, input logic fin);
        step_recs.delete();
        if (fin) begin
            // The final byte and any held zeros are payload, even when they
            // would complete a start code; afterwards a new stream begins.
            if (in_unit) begin
                release_held_zeros();
                add_payload(data);
                add_unit_end();
            end
            clear_stream_state();
        end else if (data == BYTE_ZERO) begin
            if (held_zeros < HELD_MAX) begin
                held_zeros = held_zeros + 1'b1;
            end else if (in_unit) begin
                add_payload(BYTE_ZERO);
            end
        end else if (data == BYTE_ONE && held_zeros == HELD_MAX) begin
            // Start code: close the running unit and open a fresh one.
            if (in_unit) begin
                add_unit_end();
            end
            in_unit       = 1'b1;
            held_zeros    = 2'd0;
            unit_bytes    = '0;
            unit_type_cur = 7'd0;
        end else begin
            if (in_unit) begin
                release_held_zeros();
                add_payload(data);
            end
            held_zeros = 2'd0;
        end
        if (step_recs.size() != 0) begin
            step_recs[step_recs.size() - 1].last_of_run = 1'b1;
        end
        foreach (step_recs[i]) begin
            expected_records.push_back(step_recs[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] data, input logic fin);
        t_es_item item;
        item.data = data;
        item.fin  = fin;
        stream_q.push_back(item);
    endtask

    task automatic push_start_code();
        push_byte(BYTE_ZERO, 1'b0);
        push_byte(BYTE_ZERO, 1'b0);
        push_byte(BYTE_ONE, 1'b0);
    endtask

    // Body bytes lean heavily on zeros and ones, so that runs of zeros,
    // embedded start codes and near misses show up often.
    function automatic logic [7:0] body_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return BYTE_ZERO;
        end else if (pick == 4) begin
            return BYTE_ONE;
        end else if (pick == 5) begin
            return 8'h03;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Header bytes favor the parameter set types and their neighbors.
    function automatic logic [7:0] header_byte();
        case ($urandom_range(0, 7))
            0:       return {TYPE_VPS, 1'($urandom_range(0, 1))};
            1:       return {TYPE_SPS, 1'($urandom_range(0, 1))};
            2:       return {TYPE_PPS, 1'($urandom_range(0, 1))};
            3:       return {TYPE_VPS - 7'd1, 1'b0};
            4:       return {TYPE_PPS + 7'd1, 1'b0};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // A well-formed unit: a start code, sometimes with extra leading zeros,
    // a header byte and a short body. Now and then the unit is empty, and
    // now and then it closes the stream with a final byte.
    task automatic push_unit();
        int n_lead;
        int body_len;
        int i;
        n_lead = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        for (i = 0; i < n_lead; i++) begin
            push_byte(BYTE_ZERO, 1'b0);
        end
        push_start_code();
        if ($urandom_range(0, 9) != 0) begin
            push_byte(header_byte(), 1'b0);
            body_len = $urandom_range(0, 10);
            for (i = 0; i < body_len; i++) begin
                push_byte(body_byte(), 1'b0);
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            push_byte(body_byte(), 1'b1);
        end
    endtask

    // Noise: arbitrary bytes, with an occasional final byte in the middle.
    task automatic push_noise();
        int n;
        int i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
    endtask

    initial begin
        int directed_count;

        in_bus.valid       = 1'b0;
        in_bus.stream_byte = 8'h00;
        in_bus.final_byte  = 1'b0;
        out_bus.ready      = 1'b0;

        // Directed opening.
        push_byte(8'h37, 1'b0);         // before any start code: dropped
        push_start_code();              // first start code, no unit to close
        push_byte(8'h40, 1'b0);         // header of a VPS unit
        push_byte(BYTE_ZERO, 1'b0);
        push_byte(BYTE_ZERO, 1'b0);
        push_byte(BYTE_ZERO, 1'b0);     // third zero releases one as payload
        push_byte(BYTE_ZERO, 1'b0);
        push_byte(BYTE_ONE, 1'b0);      // start code closes the VPS unit
        push_start_code();              // back to back: the empty unit is dropped
        push_byte(8'hFF, 1'b0);         // all ones header
        push_byte(BYTE_ZERO, 1'b0);
        push_byte(BYTE_ONE, 1'b0);      // one held zero and 01 is plain payload
        push_byte(BYTE_ZERO, 1'b0);
        push_byte(BYTE_ZERO, 1'b0);
        push_byte(BYTE_ONE, 1'b1);      // final byte completing a start code
        push_byte(BYTE_ZERO, 1'b1);     // final byte with no unit open
        push_start_code();
        push_byte(8'h42, 1'b0);         // SPS header
        push_start_code();
        push_byte(8'h44, 1'b1);         // PPS unit of one final byte
        directed_count = stream_q.size();

        // Randomized part: mostly well-formed units, some noise.
        while (stream_q.size() < directed_count + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                push_noise();
            end else begin
                push_unit();
            end
        end

        // Wait for every byte to go in and every record to come out, then
        // give the block time to show anything it should not.
        @(posedge i_rst_n);
        while (stream_q.size() != 0 || in_bus.valid || expected_records.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d stream bytes (%0d final) and %0d output records.",
                 bytes_sent, streams_closed, records_seen);
        $display("Checked %0d unit ends, %0d of them parameter sets; %0d mismatches.",
                 units_ended, ps_units, mismatches);
        if (mismatches == 0 && expected_records.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver. A transaction completes at an edge where valid and ready were
    // both high; that byte goes to the predictor, and the next one is offered
    // unless the sender decides to idle this cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                split_byte(in_bus.stream_byte, in_bus.final_byte);
                bytes_sent     <= bytes_sent + 1;
                streams_closed <= streams_closed + int'(in_bus.final_byte);
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_bus.valid       <= 1'b1;
                    in_bus.stream_byte <= stream_q[0].data;
                    in_bus.final_byte  <= stream_q[0].fin;
                    void'(stream_q.pop_front());
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down in its own process.
    always @(posedge i_clk) begin
        if (!hold_done && bytes_sent >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each completed output transaction is compared field by field
    // with the oldest expected record.
    // ------------------------------------------------------------------------
    task automatic check_record();
        t_nal_rec got;
        t_nal_rec want;
        got.kind             = out_bus.kind;
        got.payload_byte     = out_bus.payload_byte;
        got.unit_length      = out_bus.unit_length;
        got.unit_type        = out_bus.unit_type;
        got.is_parameter_set = out_bus.is_parameter_set;
        got.last_of_run      = out_bus.last_of_run;
        records_seen++;
        if (expected_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected record at cycle %0d: kind %0d byte %02h len %0d type %0d",
                         cycle_count, got.kind, got.payload_byte, got.unit_length,
                         got.unit_type);
            end
            return;
        end
        want = expected_records.pop_front();
        if (want.kind == KIND_END) begin
            units_ended++;
            ps_units += int'(want.is_parameter_set);
        end
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.unit_length !== want.unit_length || got.unit_type !== want.unit_type ||
            got.is_parameter_set !== want.is_parameter_set ||
            got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch at cycle %0d, record %0d:", cycle_count, records_seen);
                $display("  expected kind %0d byte %02h len %0d type %0d ps %0d last %0d",
                         want.kind, want.payload_byte, want.unit_length, want.unit_type,
                         want.is_parameter_set, want.last_of_run);
                $display("  actual   kind %0d byte %02h len %0d type %0d ps %0d last %0d",
                         got.kind, got.payload_byte, got.unit_length, got.unit_type,
                         got.is_parameter_set, got.last_of_run);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                check_record();
            end
            out_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d records still expected.",
                     cycle_count, expected_records.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule

@@ files.f @@
rtl/anb_pkg.sv
rtl/anb_if.sv
rtl/anb_front.sv
rtl/anb_queue.sv
rtl/anb_back.sv
rtl/annexb_nal_unit_splitter.sv
tb/sv/tb_annexb_nal_unit_splitter.sv
